// File: src/swcm_pkg.sv
`default_nettype none

package swcm_pkg;

  // Default fraction width of the divider quotient t
  localparam int unsigned FractionBitsDef = 16;

  // Segment index bits taken from the top of t
  localparam int unsigned SegBits = 5;

  // Threshold registers and pixel widths
  localparam int unsigned ThrW = 9;
  localparam int unsigned PixW = 8;

  // Q8 table value width and widest step between neighbouring entries
  localparam int unsigned TabW  = 16;
  localparam int unsigned DiffW = 12;

  // APB register map
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam logic        RegLow  = 1'b0;
  localparam logic        RegHigh = 1'b1;

  // Raised-cosine table: entry k = round(256 * 127.5 * (1 - cos(pi*k/32)))
  localparam int unsigned TabDepth = 33;
  localparam int unsigned TabIdxW  = 6;
  localparam logic [TabW-1:0] RC_TABLE [TabDepth] = '{
    16'd0,     16'd157,   16'd627,   16'd1405,  16'd2485,  16'd3854,  16'd5501,  16'd7409,
    16'd9560,  16'd11933, 16'd14506, 16'd17254, 16'd20149, 16'd23165, 16'd26272, 16'd29441,
    16'd32640, 16'd35839, 16'd39008, 16'd42115, 16'd45131, 16'd48026, 16'd50774, 16'd53347,
    16'd55720, 16'd57871, 16'd59779, 16'd61426, 16'd62795, 16'd63875, 16'd64653, 16'd65123,
    16'd65280
  };

  // Zone a pixel falls into
  typedef enum logic [1:0] {
    ZONE_MID,
    ZONE_BLACK,
    ZONE_WHITE
  } zone_e;

endpackage

`default_nettype wire

// File: src/sinusoidal_window_contrast_map_unit.sv
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+--------------------------------
// pixel in  | input     | in_valid_i / in_ready_o | pixel_in_i  [7:0] unsigned
// pixel out | output    | out_valid_o/out_ready_i | pixel_out_o [7:0] unsigned
// config    | input     | APB psel/penable/pwrite | paddr [2:0], pwdata/prdata [31:0]
//
// One pixel transaction enters per cycle while in_ready_o is high; the pipeline is
// FRACTION_BITS + 4 register stages deep (entry, one restoring-divider stage per
// quotient bit, table lookup, interpolation multiply, output register).
// Reset clears every valid bit and loads low_threshold = 0, high_threshold = 255.
// When the output register holds a result that is not taken, the whole pipeline holds;
// nothing is lost or repeated, and in_ready_o follows out_ready_i in that cycle.

module sinusoidal_window_contrast_map_unit #(
  parameter int unsigned FRACTION_BITS = swcm_pkg::FractionBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pixel input
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [swcm_pkg::PixW-1:0]     pixel_in_i,
  // pixel output
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [swcm_pkg::PixW-1:0]     pixel_out_o,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [swcm_pkg::AddrW-1:0]    paddr,
  input  wire logic [swcm_pkg::DataW-1:0]    pwdata,
  output      logic [swcm_pkg::DataW-1:0]    prdata,
  output      logic                          pready
);

  localparam int unsigned Fb     = FRACTION_BITS;
  localparam int unsigned Wb     = FRACTION_BITS - swcm_pkg::SegBits;
  localparam int unsigned ThrW   = swcm_pkg::ThrW;
  localparam int unsigned PixW   = swcm_pkg::PixW;
  localparam int unsigned TabW   = swcm_pkg::TabW;
  localparam int unsigned DiffW  = swcm_pkg::DiffW;
  localparam int unsigned ProdW  = DiffW + Wb;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ThrW-1:0] low_q, high_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= ThrW'(255);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        swcm_pkg::RegLow:  low_q  <= pwdata[ThrW-1:0];
        swcm_pkg::RegHigh: high_q <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      swcm_pkg::RegLow:  prdata = {{(swcm_pkg::DataW-ThrW){1'b0}}, low_q};
      swcm_pkg::RegHigh: prdata = {{(swcm_pkg::DataW-ThrW){1'b0}}, high_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register is free or
  // its result is being taken.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv         = ~out_valid_q | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Entry stage: classify the pixel and form offset and span.
  // Stage index 0 is the entry register, 1..Fb the divider stages.
  // ---------------------------------------------------------------------------
  logic                   vld_q  [Fb+1];
  swcm_pkg::zone_e        zone_q [Fb+1];
  logic [ThrW-1:0]        rem_q  [Fb+1];
  logic [ThrW-1:0]        span_q [Fb+1];
  logic [Fb-1:0]          quo_q  [Fb+1];

  logic [ThrW-1:0]        pix_ext;
  swcm_pkg::zone_e        zone_d;
  logic [ThrW-1:0]        offset_d;
  logic [ThrW-1:0]        span_d;

  assign pix_ext = {1'b0, pixel_in_i};

  always_comb begin
    if (pix_ext < low_q) begin
      zone_d = swcm_pkg::ZONE_BLACK;
    end else if (pix_ext < high_q) begin
      zone_d = swcm_pkg::ZONE_MID;
    end else begin
      zone_d = swcm_pkg::ZONE_WHITE;
    end
    // Only meaningful in the middle zone, where low <= v < high
    offset_d = pix_ext - low_q;
    span_d   = high_q - low_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zone_q[0] <= zone_d;
      rem_q[0]  <= offset_d;
      span_q[0] <= span_d;
      quo_q[0]  <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage. The remainder stays below
  // the span, so it fits the threshold width; the doubled value needs one more.
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k <= Fb; k++) begin : g_div
    logic [ThrW:0]   dbl;
    logic            ge;
    logic [ThrW:0]   diff;

    assign dbl  = {rem_q[k-1], 1'b0};
    assign ge   = dbl >= {1'b0, span_q[k-1]};
    assign diff = dbl - {1'b0, span_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        zone_q[k] <= zone_q[k-1];
        span_q[k] <= span_q[k-1];
        rem_q[k]  <= ge ? diff[ThrW-1:0] : dbl[ThrW-1:0];
        quo_q[k]  <= {quo_q[k-1][Fb-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup stage: segment from the top bits of t, weight from the rest.
  // ---------------------------------------------------------------------------
  logic [swcm_pkg::SegBits-1:0]  seg;
  logic [swcm_pkg::TabIdxW-1:0]  idx_a, idx_b;
  logic [TabW-1:0]               tab_a, tab_b, tab_diff;

  logic                          lk_vld_q;
  swcm_pkg::zone_e               lk_zone_q;
  logic [TabW-1:0]               lk_a_q;
  logic [DiffW-1:0]              lk_diff_q;
  logic [Wb-1:0]                 lk_w_q;

  assign seg      = quo_q[Fb][Fb-1 -: swcm_pkg::SegBits];
  assign idx_a    = {1'b0, seg};
  assign idx_b    = idx_a + swcm_pkg::TabIdxW'(1);
  assign tab_a    = swcm_pkg::RC_TABLE[idx_a];
  assign tab_b    = swcm_pkg::RC_TABLE[idx_b];
  assign tab_diff = tab_b - tab_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_vld_q <= 1'b0;
    end else if (adv) begin
      lk_vld_q <= vld_q[Fb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lk_zone_q <= zone_q[Fb];
      lk_a_q    <= tab_a;
      lk_diff_q <= tab_diff[DiffW-1:0];
      lk_w_q    <= quo_q[Fb][Wb-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: scale the step between neighbouring entries by the weight.
  // ---------------------------------------------------------------------------
  logic              mu_vld_q;
  swcm_pkg::zone_e   mu_zone_q;
  logic [TabW-1:0]   mu_a_q;
  logic [ProdW-1:0]  mu_prod_q;
  logic [ProdW-1:0]  prod_d;

  assign prod_d = ProdW'(lk_diff_q) * ProdW'(lk_w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (adv) begin
      mu_vld_q <= lk_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_zone_q <= lk_zone_q;
      mu_a_q    <= lk_a_q;
      mu_prod_q <= prod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: add, drop the Q8 fraction, saturate, apply the zone.
  // ---------------------------------------------------------------------------
  logic [TabW:0]    q8;
  logic [PixW:0]    level;
  logic [PixW-1:0]  curve;
  logic [PixW-1:0]  pixel_out_d;
  logic [PixW-1:0]  pixel_out_q;

  assign q8    = {1'b0, mu_a_q} + (TabW+1)'(mu_prod_q[Wb +: DiffW]);
  assign level = q8[TabW -: (PixW+1)];
  assign curve = level[PixW] ? {PixW{1'b1}} : level[PixW-1:0];

  always_comb begin
    case (mu_zone_q)
      swcm_pkg::ZONE_BLACK: pixel_out_d = '0;
      swcm_pkg::ZONE_WHITE: pixel_out_d = {PixW{1'b1}};
      swcm_pkg::ZONE_MID:   pixel_out_d = curve;
      default:              pixel_out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mu_vld_q;
    end
  end

  // Hold the result while the sink stalls
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_out_q <= pixel_out_d;
    end
  end

  assign pixel_out_o = pixel_out_q;

endmodule

`default_nettype wire

// File: tb/sinusoidal_window_contrast_map_unit_tb.sv
`timescale 1ns / 1ps

module sinusoidal_window_contrast_map_unit_tb;

  // Clock period 4 ns, and the length of reset in clock cycles
  localparam int unsigned ClkHalf    = 2;
  localparam int unsigned ResetCycles = 2;

  // Entry, one divider stage per quotient bit, lookup, multiply, output register
  localparam int unsigned PipeDepth  = swcm_pkg::FractionBitsDef + 4;
  localparam int unsigned FracBits   = swcm_pkg::FractionBitsDef;
  localparam int unsigned WeightBits = FracBits - swcm_pkg::SegBits;

  // Register map: one 32-bit word per threshold
  localparam logic [swcm_pkg::AddrW-1:0] LowAddr  = {swcm_pkg::RegLow, 2'b00};
  localparam logic [swcm_pkg::AddrW-1:0] HighAddr = {swcm_pkg::RegHigh, 2'b00};
  localparam logic [swcm_pkg::ThrW-1:0]  ThrMax   = '1;

  localparam logic [swcm_pkg::PixW-1:0]  Black = '0;
  localparam logic [swcm_pkg::PixW-1:0]  White = '1;

  // Slowest legal run: every transaction waits out the longest source gap and
  // the longest sink stall on top of the pipeline; take that several times over
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [swcm_pkg::PixW-1:0]     pixel_in_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [swcm_pkg::PixW-1:0]     pixel_out_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [swcm_pkg::AddrW-1:0]    paddr;
  logic [swcm_pkg::DataW-1:0]    pwdata;
  logic [swcm_pkg::DataW-1:0]    prdata;
  logic                          pready;

  // Shadow copy of the threshold registers
  logic [swcm_pkg::ThrW-1:0] low_thr;
  logic [swcm_pkg::ThrW-1:0] high_thr;

  // Grey levels still owed by the block, oldest first
  logic [swcm_pkg::PixW-1:0] pending_levels[$];

  int unsigned error_count;
  int unsigned cycle_count;

  // Idling controls shared between the stimulus and the sink
  bit          src_gaps_on;
  bit          sink_stalls_on;
  int unsigned sink_hold_req;

  sinusoidal_window_contrast_map_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Abort a run that hangs; the limit is far above any legal run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (!enabled || roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Expected grey level: three-zone window, raised-cosine curve in between.
  // t is the truncated quotient; its top bits pick a table segment and the
  // rest weight a straight line between the two entries (Q8 levels).
  function automatic logic [swcm_pkg::PixW-1:0] window_level(
    input logic [swcm_pkg::PixW-1:0] pix,
    input logic [swcm_pkg::ThrW-1:0] lo,
    input logic [swcm_pkg::ThrW-1:0] hi
  );
    logic [31:0] offset;
    logic [31:0] span;
    logic [31:0] frac;
    logic [31:0] seg;
    logic [31:0] weight;
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] q8;
    logic [31:0] level;
    if ({1'b0, pix} < lo) return Black;
    if ({1'b0, pix} >= hi) return White;
    offset = 32'({1'b0, pix} - lo);
    span   = 32'(hi - lo);
    frac   = (offset << FracBits) / span;
    seg    = frac >> WeightBits;
    weight = frac & ((32'd1 << WeightBits) - 32'd1);
    lower  = 32'(swcm_pkg::RC_TABLE[seg]);
    upper  = 32'(swcm_pkg::RC_TABLE[seg + 1]);
    q8     = lower + (((upper - lower) * weight) >> WeightBits);
    level  = q8 >> 8;
    return (level > 32'd255) ? White : level[swcm_pkg::PixW-1:0];
  endfunction

  // Random pixel, half of them aimed into the curved zone when it exists
  function automatic logic [swcm_pkg::PixW-1:0] pick_pixel();
    int unsigned top;
    if ($urandom_range(1, 0) == 1 && low_thr < high_thr && low_thr <= 255) begin
      top = (high_thr > 256) ? 255 : high_thr - 1;
      return swcm_pkg::PixW'($urandom_range(top, low_thr));
    end
    return swcm_pkg::PixW'($urandom_range(255, 0));
  endfunction

  // Offer one pixel, hold it until the transaction completes, then book its level
  task automatic send_pixel(input logic [swcm_pkg::PixW-1:0] pix);
    int unsigned gap;
    gap = pick_gap(src_gaps_on);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    pending_levels.push_back(window_level(pix, low_thr, high_thr));
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  // Let anything still in flight leave before touching registers or ending
  task automatic settle();
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready, then back to idle
  task automatic write_reg(input logic [swcm_pkg::AddrW-1:0] addr,
                           input logic [swcm_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LowAddr) low_thr = value[swcm_pkg::ThrW-1:0];
    else high_thr = value[swcm_pkg::ThrW-1:0];
    @(posedge clk_i);
  endtask

  // APB read, compared against the shadow copy
  task automatic read_reg(input logic [swcm_pkg::AddrW-1:0] addr);
    logic [swcm_pkg::DataW-1:0] want;
    want = swcm_pkg::DataW'((addr == LowAddr) ? low_thr : high_thr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register at %0d mismatch, expected %0d, got %0d",
               $time, addr, want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program both thresholds with junk above bit 8, then read them back
  task automatic set_window(input logic [swcm_pkg::ThrW-1:0] lo,
                            input logic [swcm_pkg::ThrW-1:0] hi);
    settle();
    write_reg(LowAddr, ($urandom() & ~32'h1FF) | 32'(lo));
    write_reg(HighAddr, ($urandom() & ~32'h1FF) | 32'(hi));
    read_reg(LowAddr);
    read_reg(HighAddr);
  endtask

  task automatic send_list(input logic [swcm_pkg::PixW-1:0] pixels[$]);
    foreach (pixels[i]) send_pixel(pixels[i]);
    end_burst();
    wait_drained();
  endtask

  // Reset values and the ends of the default window
  task automatic test_reset_window();
    read_reg(LowAddr);
    read_reg(HighAddr);
    send_list('{8'd0, 8'd1, 8'd128, 8'd254, 8'd255});
  endtask

  // Low at or above high: below low is black, everything else white
  task automatic test_crossed_window();
    set_window(9'd200, 9'd100);
    send_list('{8'd150, 8'd199, 8'd200});
    set_window(9'd128, 9'd128);
    send_list('{8'd127, 8'd128});
  endtask

  // Spans of one and two levels, and the window at the top of the range
  task automatic test_narrow_window();
    set_window(9'd10, 9'd11);
    send_list('{8'd9, 8'd10, 8'd11});
    set_window(9'd254, 9'd256);
    send_list('{8'd253, 8'd254, 8'd255});
  endtask

  // Thresholds beyond the pixel range, and everything-white
  task automatic test_wide_thresholds();
    set_window(9'd0, ThrMax);
    send_list('{8'd0, 8'd255});
    set_window(ThrMax, 9'd0);
    send_list('{8'd255});
    set_window(9'd0, 9'd0);
    send_list('{8'd0});
  endtask

  // Random windows, each phase with one of four mixes of source and sink idling
  task automatic test_random_windows();
    logic [swcm_pkg::ThrW-1:0] lo;
    logic [swcm_pkg::ThrW-1:0] hi;
    for (int phase = 0; phase < 13; phase++) begin
      case ($urandom_range(7, 0))
        0: begin
          lo = swcm_pkg::ThrW'($urandom_range(511, 0));
          hi = swcm_pkg::ThrW'($urandom_range(511, 0));
        end
        1: begin
          lo = '0;
          hi = swcm_pkg::ThrW'($urandom_range(511, 256));
        end
        2: begin
          lo = swcm_pkg::ThrW'($urandom_range(255, 0));
          hi = lo + swcm_pkg::ThrW'($urandom_range(2, 1));
        end
        default: begin
          lo = swcm_pkg::ThrW'($urandom_range(200, 0));
          hi = swcm_pkg::ThrW'($urandom_range(256, lo + 1));
        end
      endcase
      set_window(lo, hi);
      src_gaps_on    = (phase % 4 == 0) || (phase % 4 == 2);
      sink_stalls_on = (phase % 4 == 0) || (phase % 4 == 1);
      for (int n = 0; n < 100; n++) send_pixel(pick_pixel());
      end_burst();
      wait_drained();
    end
  endtask

  // Hold the sink off long enough to fill the pipeline while pixels keep coming,
  // then pause the source until everything is back before the next burst
  task automatic test_backpressure();
    set_window(9'd30, 9'd220);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b1;
    sink_hold_req  = 200;
    for (int n = 0; n < 120; n++) send_pixel(pick_pixel());
    for (int n = 0; n < 60; n++) send_pixel(pick_pixel());
    end_burst();
    wait_drained();
    src_gaps_on = 1'b1;
    for (int n = 0; n < 60; n++) send_pixel(pick_pixel());
    end_burst();
    wait_drained();
  endtask

  // Sink: random stalls, or one long hold-off when a test asks for it
  initial begin : result_sink
    int unsigned hold;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req != 0) begin
        hold = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        hold = pick_gap(sink_stalls_on);
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Compare every completed output transaction against the oldest booked level
  always @(posedge clk_i) begin : level_check
    logic [swcm_pkg::PixW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected pixel_out %0d, expected none", $time, pixel_out_o);
        error_count++;
      end else begin
        want = pending_levels.pop_front();
        if (pixel_out_o !== want) begin
          $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                   $time, want, pixel_out_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count    = 0;
    cycle_count    = 0;
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    sink_hold_req  = 0;
    low_thr        = 9'd0;
    high_thr       = 9'd255;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    pixel_in_i <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_crossed_window();
    test_narrow_window();
    test_wide_thresholds();
    test_random_windows();
    test_backpressure();

    // Drain, give the pipeline time to show any stray output, then report
    wait_drained();
    settle();
    if (pending_levels.size() != 0) begin
      $display("%0t: %0d pixel_out levels never arrived, expected 0 left",
               $time, pending_levels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
